>>> rtl/core/erpt_pkg.sv
package erpt_pkg;

  localparam int ANGLE_STEPS    = 256;
  localparam int ANGLE_W        = $clog2(ANGLE_STEPS);
  localparam int QUARTER        = ANGLE_STEPS / 4;
  localparam int HALF_TURN      = ANGLE_STEPS / 2;
  localparam int COORD_WIDTH    = 32;
  localparam int TRIG_FRAC_BITS = 14;
  localparam int TRIG_W         = TRIG_FRAC_BITS + 2;
  localparam int CFG_DATA_W     = 8;
  localparam int CFG_IDX_W      = 2;
  localparam int NUM_AXES       = 3;
  localparam int NUM_COEF       = NUM_AXES * NUM_AXES;
  localparam int COEF_IDX_W     = $clog2(NUM_COEF);

  // matrix positions, row-major
  localparam int M00 = 0;
  localparam int M01 = 1;
  localparam int M02 = 2;
  localparam int M10 = 3;
  localparam int M11 = 4;
  localparam int M12 = 5;
  localparam int M20 = 6;
  localparam int M21 = 7;
  localparam int M22 = 8;

  typedef logic signed [TRIG_W-1:0]      trig_t;
  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef trig_t                         coef_arr_t [NUM_COEF];

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ANGLE_X = CFG_IDX_W'(0),
    REG_ANGLE_Y = CFG_IDX_W'(1),
    REG_ANGLE_Z = CFG_IDX_W'(2)
  } cfg_reg_e;

  localparam trig_t TRIG_ONE = trig_t'(1 << TRIG_FRAC_BITS);

  // pi/2 in unsigned Q60
  localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1846;

  function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // taylor series of sine over the first quarter turn
  function automatic trig_t quarter_sine(int j);
    logic [63:0] jj;
    logic [63:0] theta;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    jj    = 64'(j);
    theta = (HALF_PI_Q60 / QUARTER) * jj + ((HALF_PI_Q60 % QUARTER) * jj) / QUARTER;
    x2    = mul_q60(theta, theta);
    term  = theta;
    sum   = theta;
    for (int k = 1; k <= 13; k++) begin
      term = mul_q60(term, x2) / 64'((2 * k) * (2 * k + 1));
      if (k[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    sum = sum + (64'd1 << (59 - TRIG_FRAC_BITS));
    return trig_t'(sum >> (60 - TRIG_FRAC_BITS));
  endfunction

  function automatic logic [ANGLE_STEPS*TRIG_W-1:0] build_sine_table();
    logic [ANGLE_STEPS*TRIG_W-1:0] tbl;
    trig_t                         v;
    tbl = '0;
    for (int i = 0; i < ANGLE_STEPS; i++) begin
      if (i < QUARTER) begin
        v = quarter_sine(i);
      end else if (i < HALF_TURN) begin
        v = quarter_sine(HALF_TURN - i);
      end else if (i < HALF_TURN + QUARTER) begin
        v = -quarter_sine(i - HALF_TURN);
      end else begin
        v = -quarter_sine(ANGLE_STEPS - i);
      end
      tbl[i*TRIG_W +: TRIG_W] = v;
    end
    return tbl;
  endfunction

  localparam logic [ANGLE_STEPS*TRIG_W-1:0] SINE_TABLE = build_sine_table();

  function automatic trig_t sine_lookup(logic [ANGLE_W-1:0] idx);
    return trig_t'(SINE_TABLE[idx*TRIG_W +: TRIG_W]);
  endfunction

endpackage

>>> rtl/core/erpt_coef_gen.sv
module erpt_coef_gen (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [erpt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [erpt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                           busy_o,
  output erpt_pkg::coef_arr_t            coef_o
);
  import erpt_pkg::*;

  localparam int PROD2_W = 2 * TRIG_W;
  localparam int PROD3_W = 3 * TRIG_W;
  localparam int SUM_W   = PROD3_W + 1;
  localparam int SHIFT   = 2 * TRIG_FRAC_BITS;

  localparam logic signed [SUM_W-1:0] RND_BIAS = SUM_W'(1) <<< (SHIFT - 1);
  localparam logic signed [SUM_W-1:0] CLAMP_HI = SUM_W'(1) <<< TRIG_FRAC_BITS;
  localparam logic signed [SUM_W-1:0] CLAMP_LO = -CLAMP_HI;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_LOAD  = 4'b0010,
    ST_RUN   = 4'b0100,
    ST_DRAIN = 4'b1000
  } gen_state_e;

  gen_state_e state_q, state_d;

  logic [CFG_DATA_W-1:0] ang_x_q, ang_y_q, ang_z_q;
  logic [ANGLE_W-1:0]    ax, ay, az;
  logic                  cfg_we, rebuild;

  trig_t sx_q, cx_q, sy_q, cy_q, sz_q, cz_q;

  logic [COEF_IDX_W-1:0] idx_q, idx1_q, idx2_q, idx3_q;
  logic                  v1_q, v2_q, v3_q;

  trig_t op_a, op_b, op_c, op_d, op_e, op_f;
  logic  neg_a, neg_d;

  logic signed [PROD2_W-1:0] p_ab_q, p_de_q;
  trig_t                     c1_q, f1_q;
  logic                      neg_a1_q, neg_d1_q, neg_a2_q, neg_d2_q;
  logic signed [PROD3_W-1:0] t1_q, t2_q;
  logic signed [SUM_W-1:0]   sum_q, rnd;
  trig_t                     coef_new;
  coef_arr_t                 coef_q;

  assign cfg_ready_o = (state_q == ST_IDLE);
  assign busy_o      = !cfg_ready_o;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign rebuild     = cfg_we && (cfg_idx_i == REG_ANGLE_X || cfg_idx_i == REG_ANGLE_Y ||
                                  cfg_idx_i == REG_ANGLE_Z);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang_x_q <= '0;
      ang_y_q <= '0;
      ang_z_q <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_i)
        REG_ANGLE_X: ang_x_q <= cfg_data_i;
        REG_ANGLE_Y: ang_y_q <= cfg_data_i;
        REG_ANGLE_Z: ang_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // angles wrap on the low bits
  assign ax = ANGLE_W'(ang_x_q);
  assign ay = ANGLE_W'(ang_y_q);
  assign az = ANGLE_W'(ang_z_q);

  always_ff @(posedge clk_i) begin
    sx_q <= sine_lookup(ax);
    cx_q <= sine_lookup(ax + ANGLE_W'(QUARTER));
    sy_q <= sine_lookup(ay);
    cy_q <= sine_lookup(ay + ANGLE_W'(QUARTER));
    sz_q <= sine_lookup(az);
    cz_q <= sine_lookup(az + ANGLE_W'(QUARTER));
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (rebuild) state_d = ST_LOAD;
      ST_LOAD:  state_d = ST_RUN;
      ST_RUN:   if (idx_q == COEF_IDX_W'(NUM_COEF - 1)) state_d = ST_DRAIN;
      ST_DRAIN: if (!v1_q && !v2_q && !v3_q) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_RUN) begin
        idx_q <= idx_q + COEF_IDX_W'(1);
      end else begin
        idx_q <= '0;
      end
      v1_q <= (state_q == ST_RUN);
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // each coefficient is +-a*b*c +- d*e*f
  always_comb begin
    op_a  = '0;
    op_b  = '0;
    op_c  = '0;
    op_d  = '0;
    op_e  = '0;
    op_f  = '0;
    neg_a = 1'b0;
    neg_d = 1'b0;
    unique case (idx_q)
      M00: begin
        op_a = cy_q; op_b = cz_q; op_c = TRIG_ONE;
      end
      M01: begin
        op_a = cy_q; op_b = sz_q; op_c = TRIG_ONE;
      end
      M02: begin
        op_a = sy_q; op_b = TRIG_ONE; op_c = TRIG_ONE; neg_a = 1'b1;
      end
      M10: begin
        op_a = sx_q; op_b = sy_q; op_c = cz_q;
        op_d = cx_q; op_e = sz_q; op_f = TRIG_ONE; neg_d = 1'b1;
      end
      M11: begin
        op_a = sx_q; op_b = sy_q; op_c = sz_q;
        op_d = cx_q; op_e = cz_q; op_f = TRIG_ONE;
      end
      M12: begin
        op_a = cy_q; op_b = sx_q; op_c = TRIG_ONE;
      end
      M20: begin
        op_a = cx_q; op_b = sy_q; op_c = cz_q;
        op_d = sx_q; op_e = sz_q; op_f = TRIG_ONE;
      end
      M21: begin
        op_a = cx_q; op_b = sy_q; op_c = sz_q;
        op_d = sx_q; op_e = cz_q; op_f = TRIG_ONE; neg_d = 1'b1;
      end
      M22: begin
        op_a = cx_q; op_b = cy_q; op_c = TRIG_ONE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    p_ab_q   <= PROD2_W'(op_a) * PROD2_W'(op_b);
    p_de_q   <= PROD2_W'(op_d) * PROD2_W'(op_e);
    c1_q     <= op_c;
    f1_q     <= op_f;
    neg_a1_q <= neg_a;
    neg_d1_q <= neg_d;
    idx1_q   <= idx_q;

    t1_q     <= PROD3_W'(p_ab_q) * PROD3_W'(c1_q);
    t2_q     <= PROD3_W'(p_de_q) * PROD3_W'(f1_q);
    neg_a2_q <= neg_a1_q;
    neg_d2_q <= neg_d1_q;
    idx2_q   <= idx1_q;

    sum_q  <= (neg_a2_q ? -SUM_W'(t1_q) : SUM_W'(t1_q)) +
              (neg_d2_q ? -SUM_W'(t2_q) : SUM_W'(t2_q));
    idx3_q <= idx2_q;
  end

  always_comb begin
    rnd = (sum_q + RND_BIAS) >>> SHIFT;
    if (rnd > CLAMP_HI) begin
      coef_new = trig_t'(CLAMP_HI);
    end else if (rnd < CLAMP_LO) begin
      coef_new = trig_t'(CLAMP_LO);
    end else begin
      coef_new = trig_t'(rnd);
    end
  end

  // reset angles are zero, so the matrix starts as identity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_COEF; k++) begin
        coef_q[k] <= (k == M00 || k == M11 || k == M22) ? TRIG_ONE : '0;
      end
    end else if (v3_q) begin
      coef_q[idx3_q] <= coef_new;
    end
  end

  assign coef_o = coef_q;

endmodule

>>> rtl/core/erpt_point_pipe.sv
module erpt_point_pipe (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                hold_i,
  input  erpt_pkg::coef_arr_t coef_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  erpt_pkg::coord_t    point_x_i,
  input  erpt_pkg::coord_t    point_y_i,
  input  erpt_pkg::coord_t    point_z_i,
  input  logic                last_point_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output erpt_pkg::coord_t    rotated_x_o,
  output erpt_pkg::coord_t    rotated_y_o,
  output erpt_pkg::coord_t    rotated_z_o,
  output logic                last_out_o
);
  import erpt_pkg::*;

  localparam int PMUL_W = COORD_WIDTH + TRIG_W;
  localparam int DOT_W  = PMUL_W + 2;

  localparam logic signed [DOT_W-1:0] RND_BIAS = DOT_W'(1) <<< (TRIG_FRAC_BITS - 1);
  localparam logic signed [DOT_W-1:0] SAT_MAX  = (DOT_W'(1) <<< (COORD_WIDTH - 1)) - DOT_W'(1);
  localparam logic signed [DOT_W-1:0] SAT_MIN  = -(DOT_W'(1) <<< (COORD_WIDTH - 1));

  logic en0, en1, en2, en3, accept;
  logic v0_q, v1_q, v2_q, v3_q;
  logic last0_q, last1_q, last2_q, last3_q;

  coord_t                   pt_q   [NUM_AXES];
  logic signed [PMUL_W-1:0] prod_q [NUM_AXES][NUM_AXES];
  logic signed [DOT_W-1:0]  dot_q  [NUM_AXES];
  logic signed [DOT_W-1:0]  rnd    [NUM_AXES];
  coord_t                   sat    [NUM_AXES];
  coord_t                   rot_q  [NUM_AXES];

  assign en3        = !v3_q || !out_stall_i;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign en0        = !v0_q || en1;
  assign in_stall_o = !en0 || hold_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en0) v0_q <= accept;
      if (en1) v1_q <= v0_q;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // round half up, then saturate to the coordinate range
  always_comb begin
    for (int j = 0; j < NUM_AXES; j++) begin
      rnd[j] = (dot_q[j] + RND_BIAS) >>> TRIG_FRAC_BITS;
      if (rnd[j] > SAT_MAX) begin
        sat[j] = coord_t'(SAT_MAX);
      end else if (rnd[j] < SAT_MIN) begin
        sat[j] = coord_t'(SAT_MIN);
      end else begin
        sat[j] = coord_t'(rnd[j]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en0) begin
      pt_q[0] <= point_x_i;
      pt_q[1] <= point_y_i;
      pt_q[2] <= point_z_i;
      last0_q <= last_point_i;
    end
    if (en1) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        for (int j = 0; j < NUM_AXES; j++) begin
          prod_q[i][j] <= PMUL_W'(pt_q[i]) * PMUL_W'(coef_i[NUM_AXES*i + j]);
        end
      end
      last1_q <= last0_q;
    end
    if (en2) begin
      for (int j = 0; j < NUM_AXES; j++) begin
        dot_q[j] <= DOT_W'(prod_q[0][j]) + DOT_W'(prod_q[1][j]) + DOT_W'(prod_q[2][j]);
      end
      last2_q <= last1_q;
    end
    if (en3) begin
      for (int j = 0; j < NUM_AXES; j++) begin
        rot_q[j] <= sat[j];
      end
      last3_q <= last2_q;
    end
  end

  assign out_valid_o = v3_q;
  assign rotated_x_o = rot_q[0];
  assign rotated_y_o = rot_q[1];
  assign rotated_z_o = rot_q[2];
  assign last_out_o  = last3_q;

endmodule

>>> rtl/core/euler_rotation_point_transform.sv
// Rotates a stream of Q16.16 points (x,y,z) by the x-y-z Euler rotation matrix set by the
// three angle registers (index 0..2, angle in 1/256 turn, wrapping). One point is accepted
// per clock unless an output stall or a matrix rebuild holds the input, and its rotated
// point passes through four register stages (input register, nine 32x16 products, column
// sums, round and saturate), with the last marker carried along; output stall backs up the
// pipeline without loss. Writing an angle register starts a rebuild of the nine matrix
// coefficients on a shared pipelined datapath of three-factor products, one coefficient
// per clock; while the rebuild runs the configuration port is not ready and the input
// channel is stalled. Writes to index 3 are ignored. Write the angles only while no
// point is in flight.
module euler_rotation_point_transform (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  erpt_pkg::coord_t               point_x_i,
  input  erpt_pkg::coord_t               point_y_i,
  input  erpt_pkg::coord_t               point_z_i,
  input  logic                           last_point_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output erpt_pkg::coord_t               rotated_x_o,
  output erpt_pkg::coord_t               rotated_y_o,
  output erpt_pkg::coord_t               rotated_z_o,
  output logic                           last_out_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [erpt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [erpt_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import erpt_pkg::*;

  coef_arr_t coef;
  logic      busy;

  erpt_coef_gen u_coef_gen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .busy_o      (busy),
    .coef_o      (coef)
  );

  erpt_point_pipe u_point_pipe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .hold_i       (busy),
    .coef_i       (coef),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .point_z_i    (point_z_i),
    .last_point_i (last_point_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .rotated_x_o  (rotated_x_o),
    .rotated_y_o  (rotated_y_o),
    .rotated_z_o  (rotated_z_o),
    .last_out_o   (last_out_o)
  );

endmodule

>>> rtl/core/erpt_checker.sv
module erpt_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input erpt_pkg::coord_t               rotated_x_o,
  input erpt_pkg::coord_t               rotated_y_o,
  input erpt_pkg::coord_t               rotated_z_o,
  input logic                           last_out_o,
  input logic                           cfg_valid_i,
  input logic                           cfg_ready_o,
  input logic [erpt_pkg::CFG_IDX_W-1:0]  cfg_idx_i
);
  import erpt_pkg::*;

  // a stalled result item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(rotated_x_o) &&
      $stable(rotated_y_o) && $stable(rotated_z_o) && $stable(last_out_o))
    else $error("stalled result changed");

  // an angle write starts a rebuild that blocks both ports
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o &&
      (cfg_idx_i == REG_ANGLE_X || cfg_idx_i == REG_ANGLE_Y || cfg_idx_i == REG_ANGLE_Z)
      |=> !cfg_ready_o && in_stall_o)
    else $error("angle write did not start a rebuild");

  // no item is taken while the matrix is being rebuilt
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_ready_o |-> in_stall_o)
    else $error("input accepted during rebuild");

endmodule

bind euler_rotation_point_transform erpt_checker u_erpt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .rotated_x_o (rotated_x_o),
  .rotated_y_o (rotated_y_o),
  .rotated_z_o (rotated_z_o),
  .last_out_o  (last_out_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o),
  .cfg_idx_i   (cfg_idx_i)
);

>>> test/tb_top.sv
module tb_top;
  import erpt_pkg::*;

  localparam int ITEMS_PER_PHASE = 150;
  localparam int STREAM_PHASES   = 10;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int DRAIN_CYCLES    = 8;
  localparam real PI_VALUE       = 3.14159265358979323846;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   last;
  } point_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  coord_t                point_x_i;
  coord_t                point_y_i;
  coord_t                point_z_i;
  logic                  last_point_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  coord_t                rotated_x_o;
  coord_t                rotated_y_o;
  coord_t                rotated_z_o;
  logic                  last_out_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  longint             sine_q [ANGLE_STEPS];
  longint             coef [NUM_COEF];
  logic [ANGLE_W-1:0] turn_x;
  logic [ANGLE_W-1:0] turn_y;
  logic [ANGLE_W-1:0] turn_z;
  point_t             pending_rotations [$];
  int                 mismatch_count;
  bit                 steady_flow;

  euler_rotation_point_transform dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .point_z_i    (point_z_i),
    .last_point_i (last_point_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .rotated_x_o  (rotated_x_o),
    .rotated_y_o  (rotated_y_o),
    .rotated_z_o  (rotated_z_o),
    .last_out_o   (last_out_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("euler_rotation_point_transform: mismatch");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic void fill_sine_table();
    real angle_rad;
    for (int i = 0; i < ANGLE_STEPS; i++) begin
      angle_rad = 2.0 * PI_VALUE * i / ANGLE_STEPS;
      sine_q[i] = longint'($floor($sin(angle_rad) * (2.0 ** TRIG_FRAC_BITS) + 0.5));
    end
  endfunction

  // nearest, ties up, then clamp to +-1.0
  function automatic longint coef_round(longint p);
    longint r;
    longint unity;
    r = (p + (longint'(1) <<< (2 * TRIG_FRAC_BITS - 1))) >>> (2 * TRIG_FRAC_BITS);
    unity = longint'(1) <<< TRIG_FRAC_BITS;
    if (r > unity) r = unity;
    if (r < -unity) r = -unity;
    return r;
  endfunction

  function automatic void rebuild_matrix();
    longint sx, cx, sy, cy, sz, cz, u;
    sx = sine_q[turn_x];
    cx = sine_q[ANGLE_W'(turn_x + QUARTER)];
    sy = sine_q[turn_y];
    cy = sine_q[ANGLE_W'(turn_y + QUARTER)];
    sz = sine_q[turn_z];
    cz = sine_q[ANGLE_W'(turn_z + QUARTER)];
    u  = longint'(1) <<< TRIG_FRAC_BITS;
    coef[M00] = coef_round(cy * cz * u);
    coef[M01] = coef_round(cy * sz * u);
    coef[M02] = coef_round(-sy * u * u);
    coef[M10] = coef_round(sx * sy * cz - cx * sz * u);
    coef[M11] = coef_round(sx * sy * sz + cx * cz * u);
    coef[M12] = coef_round(cy * sx * u);
    coef[M20] = coef_round(cx * sy * cz + sx * sz * u);
    coef[M21] = coef_round(cx * sy * sz - sx * cz * u);
    coef[M22] = coef_round(cx * cy * u);
  endfunction

  function automatic void apply_angle_write(logic [CFG_IDX_W-1:0] idx,
                                            logic [CFG_DATA_W-1:0] val);
    if (idx == REG_ANGLE_X) begin
      turn_x = ANGLE_W'(val);
    end else if (idx == REG_ANGLE_Y) begin
      turn_y = ANGLE_W'(val);
    end else if (idx == REG_ANGLE_Z) begin
      turn_z = ANGLE_W'(val);
    end else begin
      return;
    end
    rebuild_matrix();
  endfunction

  function automatic coord_t rotate_axis(coord_t x, coord_t y, coord_t z,
                                         longint c0, longint c1, longint c2);
    longint acc;
    longint lim;
    acc = longint'(x) * c0 + longint'(y) * c1 + longint'(z) * c2;
    acc = (acc + (longint'(1) <<< (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS;
    lim = longint'(1) <<< (COORD_WIDTH - 1);
    if (acc > lim - 1) acc = lim - 1;
    if (acc < -lim) acc = -lim;
    return coord_t'(acc);
  endfunction

  function automatic point_t predict_rotation(coord_t x, coord_t y, coord_t z, logic last);
    point_t p;
    p.x    = rotate_axis(x, y, z, coef[M00], coef[M10], coef[M20]);
    p.y    = rotate_axis(x, y, z, coef[M01], coef[M11], coef[M21]);
    p.z    = rotate_axis(x, y, z, coef[M02], coef[M12], coef[M22]);
    p.last = last;
    return p;
  endfunction

  function automatic coord_t random_coord();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return coord_t'($urandom);
      5, 6, 7: return coord_t'(int'($urandom_range(0, 2097152)) - 1048576);
      8: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 32'sh0000_0000;
          default: return 32'shFFFF_FFFF;
        endcase
      end
      default: return coord_t'({$urandom_range(0, 1) ? 16'h7FFF : 16'h8000,
                                16'($urandom)});
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    point_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_rotations.size() == 0) begin
        $display("%0t: unexpected item expected none actual %h %h %h %b", $time,
                 rotated_x_o, rotated_y_o, rotated_z_o, last_out_o);
        mismatch_count++;
      end else begin
        want = pending_rotations.pop_front();
        check_field("rotated_x", want.x, rotated_x_o);
        check_field("rotated_y", want.y, rotated_y_o);
        check_field("rotated_z", want.z, rotated_z_o);
        check_field("last_out", 32'(want.last), 32'(last_out_o));
      end
    end
  end

  initial begin : result_pacing
    int hold;
    hold = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (steady_flow || hold == 0) begin
        out_stall_i = 1'b0;
        hold = pick_gap();
      end else begin
        out_stall_i = 1'b1;
        hold--;
      end
    end
  end

  task automatic wait_for_rotations();
    in_valid_i = 1'b0;
    while (pending_rotations.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_point(coord_t x, coord_t y, coord_t z, logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    point_x_i    = x;
    point_y_i    = y;
    point_z_i    = z;
    last_point_i = last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_rotations.push_back(predict_rotation(x, y, z, last));
    @(negedge clk_i);
  endtask

  task automatic write_angle_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    wait_for_rotations();
    cfg_valid_i = 1'b1;
    cfg_idx_i   = idx;
    cfg_data_i  = val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    apply_angle_write(idx, val);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_angles(logic [CFG_DATA_W-1:0] ax, logic [CFG_DATA_W-1:0] ay,
                            logic [CFG_DATA_W-1:0] az);
    write_angle_reg(REG_ANGLE_X, ax);
    write_angle_reg(REG_ANGLE_Y, ay);
    write_angle_reg(REG_ANGLE_Z, az);
  endtask

  // reset angles give the identity, so points pass through unchanged
  task automatic test_identity_after_reset();
    send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0001, 1'b0);
    send_point(32'sh8000_0000, 32'sh7FFF_FFFF, 32'shFFFF_FFFF, 1'b1);
    send_point(32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000, 1'b0);
    send_point(32'sh0001_0000, 32'shFFFF_0000, 32'sh0000_8000, 1'b1);
    send_point(random_coord(), random_coord(), random_coord(), 1'b0);
  endtask

  task automatic test_angle_extremes();
    set_angles(8'd255, 8'd255, 8'd255);
    send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
    send_point(32'sh0001_0000, 32'sh0002_0000, 32'shFFFD_0000, 1'b1);
    // spare index must leave the matrix alone
    write_angle_reg(REG_SPARE, 8'hFF);
    send_point(32'sh0001_0000, 32'sh0002_0000, 32'shFFFD_0000, 1'b0);
    set_angles(8'd64, 8'd128, 8'd192);
    send_point(32'sh0001_0000, 32'sh0000_0000, 32'sh0000_0000, 1'b0);
    send_point(32'sh0000_0000, 32'sh0001_0000, 32'sh0000_0000, 1'b0);
    send_point(32'sh0000_0000, 32'sh0000_0000, 32'sh0001_0000, 1'b1);
    send_point(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
  endtask

  // eighth turn about z pushes the diagonal past full scale
  task automatic test_saturation();
    set_angles(8'd0, 8'd0, 8'd32);
    send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh0000_0000, 1'b0);
    send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh0000_0000, 1'b0);
    send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000, 1'b0);
    send_point(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
  endtask

  task automatic test_random_stream();
    for (int phase = 0; phase < STREAM_PHASES; phase++) begin
      case (phase)
        0: set_angles(8'd255, 8'd255, 8'd255);
        1: set_angles(8'd0, 8'd0, 8'd0);
        2: set_angles(8'd64, 8'd128, 8'd192);
        default: begin
          if ($urandom_range(0, 3) != 0) write_angle_reg(REG_ANGLE_X, 8'($urandom));
          if ($urandom_range(0, 3) != 0) write_angle_reg(REG_ANGLE_Y, 8'($urandom));
          if ($urandom_range(0, 3) != 0) write_angle_reg(REG_ANGLE_Z, 8'($urandom));
          if (phase == 5) write_angle_reg(REG_SPARE, 8'($urandom));
        end
      endcase
      steady_flow = (phase == 3);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (phase == 4 && n == ITEMS_PER_PHASE / 2) begin
          wait_for_rotations();
        end
        send_point(random_coord(), random_coord(), random_coord(),
                   $urandom_range(0, 7) == 0);
      end
      steady_flow = 1'b0;
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    point_x_i      = '0;
    point_y_i      = '0;
    point_z_i      = '0;
    last_point_i   = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_idx_i      = REG_ANGLE_X;
    cfg_data_i     = '0;
    steady_flow    = 1'b0;
    mismatch_count = 0;
    turn_x         = '0;
    turn_y         = '0;
    turn_z         = '0;
    fill_sine_table();
    rebuild_matrix();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_identity_after_reset();
    test_angle_extremes();
    test_saturation();
    test_random_stream();

    wait_for_rotations();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("euler_rotation_point_transform: match");
    end else begin
      $display("euler_rotation_point_transform: mismatch");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/erpt_pkg.sv
rtl/core/erpt_coef_gen.sv
rtl/core/erpt_point_pipe.sv
rtl/core/euler_rotation_point_transform.sv
rtl/core/erpt_checker.sv
test/tb_top.sv
